// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- src/qat_pkg.sv -----
// ----------------------------------------------------------------------------
// qat_pkg
// Types and constants of the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EOA   = 2'd1;
   localparam logic [1:0] KIND_EOL   = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_VT     = 8'h0B;

   typedef struct packed {
      logic in_argument;
      logic in_quotes;
      logic quote_is_double;
      logic escape_pending;
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } pair_type;

endpackage

// ----- src/qat_decode.sv -----
// ----------------------------------------------------------------------------
// qat_decode
// Next-state and result logic for one byte of the command line.
// ----------------------------------------------------------------------------
module qat_decode
   import qat_pkg::*;
(
   input  state_type  state,
   input  logic [7:0] ch,
   output state_type  state_next,
   output pair_type   results
);

   state_type  st;
   pair_type   res;
   logic       blank;
   logic [7:0] quote_ch;
   result_type byte_res;
   result_type eoa_last;
   result_type eoa_more;
   result_type eol_res;
   result_type err_res;

   assign blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                  (ch == CH_CR) || (ch == CH_FF) || (ch == CH_VT);
   assign quote_ch = state.quote_is_double ? CH_DQUOTE : CH_SQUOTE;

   assign byte_res = '{kind: KIND_BYTE,  data_byte: ch,    last: 1'b1};
   assign eoa_last = '{kind: KIND_EOA,   data_byte: 8'h00, last: 1'b1};
   assign eoa_more = '{kind: KIND_EOA,   data_byte: 8'h00, last: 1'b0};
   assign eol_res  = '{kind: KIND_EOL,   data_byte: 8'h00, last: 1'b1};
   assign err_res  = '{kind: KIND_ERROR, data_byte: 8'h00, last: 1'b1};

   always_comb begin
      st  = state;
      res = '{count: 2'd0, first: byte_res, second: eol_res};
      if (ch == CH_NUL) begin
         st = '0;
         if (state.escape_pending || state.in_quotes) begin
            res.count = 2'd1;
            res.first = err_res;
         end else if (state.in_argument) begin
            res.count = 2'd2;
            res.first = eoa_more;
         end else begin
            res.count = 2'd1;
            res.first = eol_res;
         end
      end else if (state.escape_pending) begin
         st.escape_pending = 1'b0;
         st.in_argument    = 1'b1;
         res.count         = 2'd1;
      end else if (state.in_quotes) begin
         if (ch == quote_ch) begin
            st.in_quotes       = 1'b0;
            st.quote_is_double = 1'b0;
         end else if (ch == CH_BSLASH) begin
            st.escape_pending = 1'b1;
         end else begin
            res.count = 2'd1;
         end
      end else if (blank) begin
         if (state.in_argument) begin
            st.in_argument = 1'b0;
            res.count      = 2'd1;
            res.first      = eoa_last;
         end
      end else if ((ch == CH_SQUOTE) || (ch == CH_DQUOTE)) begin
         st.in_quotes       = 1'b1;
         st.quote_is_double = (ch == CH_DQUOTE);
         st.in_argument     = 1'b1;
      end else if (ch == CH_BSLASH) begin
         st.escape_pending = 1'b1;
         st.in_argument    = 1'b1;
      end else begin
         st.in_argument = 1'b1;
         res.count      = 2'd1;
      end
   end

   assign state_next = st;
   assign results    = res;

endmodule

// ----- src/qat_result_buf.sv -----
// ----------------------------------------------------------------------------
// qat_result_buf
// Two-slot result register that presents one result item at a time.
// ----------------------------------------------------------------------------
module qat_result_buf
   import qat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  pair_type   pair,
   output logic       ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last
);

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       take;

   assign take  = (count_ff != 2'd0) && !rsp_stall;
   assign ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && take);

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (take) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
      if (push) begin
         count_in = pair.count;
         slot0_in = pair.first;
         slot1_in = pair.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid     = (count_ff != 2'd0);
   assign rsp_kind      = slot0_ff.kind;
   assign rsp_data_byte = slot0_ff.data_byte;
   assign rsp_last      = slot0_ff.last;

endmodule

// ----- src/quoted_argument_tokenizer.sv -----
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a zero-terminated command line, one byte per item, into arguments.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while req_stall is low. Each byte passes
// through an input register and the tokenizer state logic into a two-slot
// result register. A byte gives zero, one or two result items; the zero byte
// that closes an open argument gives two, and while these wait at the result
// port, one further byte is held in the input register.
module quoted_argument_tokenizer
   import qat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last
);

   logic       valid_ff, valid_in;
   logic [7:0] ch_ff, ch_in;
   state_type  state_ff, state_in;
   state_type  state_next;
   pair_type   pair;
   logic       buf_ready;
   logic       advance;

   assign advance   = valid_ff && buf_ready;
   assign req_stall = valid_ff && !buf_ready;

   always_comb begin
      valid_in = valid_ff;
      ch_in    = ch_ff;
      state_in = state_ff;
      if (advance) begin
         state_in = state_next;
      end
      if (!req_stall) begin
         valid_in = req_valid;
         ch_in    = req_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         state_ff <= state_in;
      end
      ch_ff <= ch_in;
   end

   qat_decode u_decode (
      .state      (state_ff),
      .ch         (ch_ff),
      .state_next (state_next),
      .results    (pair)
   );

   qat_result_buf u_result_buf (
      .clock         (clock),
      .reset         (reset),
      .push          (advance),
      .pair          (pair),
      .ready         (buf_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- src/qat_checker.sv -----
// ----------------------------------------------------------------------------
// qat_checker
// Port-level assertions for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qat_checker
   import qat_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_ch,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_last
);

   logic rsp_take;
   logic eoa_pending;
   logic rsp_blocked;
   logic req_blocked;
   logic end_kind;
   logic eol_shown;

   assign rsp_take    = rsp_valid && !rsp_stall;
   assign eoa_pending = rsp_take && (rsp_kind == KIND_EOA) && !rsp_last;
   assign rsp_blocked = rsp_valid && rsp_stall && !reset;
   assign req_blocked = req_valid && req_stall && !reset;
   assign end_kind    = (rsp_kind == KIND_EOL) || (rsp_kind == KIND_ERROR);
   assign eol_shown   = rsp_valid && (rsp_kind == KIND_EOL) && rsp_last;

   `ASSERT_PROP(a_rsp_hold, clock, reset, $past(rsp_blocked) |-> rsp_valid, "result item dropped")
   `ASSERT_PROP(a_req_hold, clock, reset, $past(req_blocked) |-> req_ch == $past(req_ch), "input changed")
   `ASSERT_IMPL(a_data_zero, clock, reset, rsp_valid && (rsp_kind != KIND_BYTE), rsp_data_byte == 8'h00, "data nonzero")
   `ASSERT_IMPL(a_end_last, clock, reset, rsp_valid && end_kind, rsp_last, "line end without last")
   `ASSERT_PROP(a_eoa_then_eol, clock, reset, eoa_pending |=> eol_shown, "no line end after argument")

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_ch        (req_ch),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_data_byte (rsp_data_byte),
   .rsp_last      (rsp_last)
);
